### rtl/fdtf_pkg.sv
// Shared constants, types and helper functions of the decimal text formatter.
// No dependencies; used by fdtf_ctrl, fdtf_dp and the top level.
`default_nettype none
package fdtf_pkg;

  localparam int VALUE_W    = 48;
  localparam int FRAC_BITS  = 16;
  localparam int IPART_W    = VALUE_W - FRAC_BITS;
  localparam int INT_DIGITS = 10;
  localparam int MAX_FRAC   = 4;
  localparam int FDIG_W     = 14;
  localparam int PROD_W     = 32;
  localparam int CNT_W      = 5;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [1:0] REG_TOTAL_WIDTH = 2'd0;
  localparam logic [1:0] REG_MAX_FRAC    = 2'd1;
  localparam logic [1:0] REG_TRIM        = 2'd2;

  typedef struct packed {
    logic load;
    logic ddi;
    logic mul;
    logic rnd;
    logic ddf;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } sts_t;

  function automatic logic [3:0] add3(input logic [3:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  function automatic logic [FDIG_W-1:0] pow10(input logic [2:0] k);
    logic [FDIG_W-1:0] p;
    case (k)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/fdtf_ctrl.sv
// Sequencer of the decimal text formatter: steps the datapath through
// conversion, rounding and character output. Depends on fdtf_pkg.
`default_nettype none
module fdtf_ctrl import fdtf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DDI  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_DDF  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [CNT_W-1:0] DDI_LAST = CNT_W'(IPART_W - 1);
  localparam logic [CNT_W-1:0] DDF_LAST = CNT_W'(FDIG_W - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DDI;
        end
      end
      S_DDI: begin
        cmd.ddi = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DDI_LAST) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DDF;
      end
      S_DDF: begin
        cmd.ddf = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DDF_LAST) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_ddi_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DDI && cnt_r == DDI_LAST) |=> (state_r == S_MUL))
    else $error("integer conversion overran");
  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last) |=> (state_r == S_IDLE))
    else $error("no return to idle after final character");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("several commands at once");

endmodule
`default_nettype wire

### rtl/fdtf_dp.sv
// Datapath of the decimal text formatter: BCD conversion, rounding, trimming
// and the output word register. Depends on fdtf_pkg.
`default_nettype none
module fdtf_dp import fdtf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [4:0]         total_width,
  input  wire logic [2:0]         max_frac_digits,
  input  wire logic               trim_zeros,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_text_char,
  output logic                    out_last
);

  logic                            neg_r, neg_nxt;
  logic [IPART_W-1:0]              ibin_r, ibin_nxt;
  logic [FRAC_BITS-1:0]            frac_r, frac_nxt;
  logic [INT_DIGITS-1:0][3:0]      ibcd_r, ibcd_nxt;
  logic [2:0]                      k_r, k_nxt;
  logic [PROD_W-1:0]               prod_r, prod_nxt;
  logic [FDIG_W-1:0]               fbin_r, fbin_nxt;
  logic [MAX_FRAC-1:0][3:0]        fbcd_r, fbcd_nxt;
  logic [3:0]                      idig_r, idig_nxt;
  logic [2:0]                      keep_r, keep_nxt;
  logic [4:0]                      len_r, len_nxt;
  logic [4:0]                      pos_r, pos_nxt;
  logic                            ov_r, ov_nxt;
  logic [7:0]                      ch_r, ch_nxt;
  logic                            lst_r, lst_nxt;

  logic [VALUE_W-1:0]              mag;
  logic [INT_DIGITS-1:0][3:0]      it;
  logic [MAX_FRAC-1:0][3:0]        ft;
  logic [3:0]                      d_pre;
  logic [5:0]                      d_sum;
  logic [4:0]                      room;
  logic [2:0]                      nlim, k_sel;
  logic [FDIG_W-1:0]               scale;
  logic [FDIG_W:0]                 fraw;
  logic                            ge, allnine, c;
  logic [INT_DIGITS-1:0][3:0]      inc;
  logic [3:0]                      idig_c;
  logic                            izero, fzero, tz_run;
  logic [2:0]                      tz;
  logic [4:0]                      pm1, ioff, foff;
  logic [3:0]                      iidx;
  logic [1:0]                      fidx;
  logic                            out_free;

  assign out_free     = !ov_r || out_ready;
  assign sts.out_free = out_free;
  assign sts.last     = (pos_r == len_r - 5'd1);

  always_comb begin
    mag = value[VALUE_W-1] ? (~value + 1'b1) : value;

    for (int i = 0; i < INT_DIGITS; i++) it[i] = add3(ibcd_r[i]);
    for (int i = 0; i < MAX_FRAC; i++) ft[i] = add3(fbcd_r[i]);

    d_pre = 4'd1;
    for (int i = 0; i < INT_DIGITS; i++)
      if (ibcd_r[i] != 4'd0) d_pre = 4'(i + 1);
    d_sum = {2'b00, d_pre} + 6'd2;
    room  = total_width - {1'b0, d_pre} - 5'd2;
    nlim  = (max_frac_digits > 3'(MAX_FRAC)) ? 3'(MAX_FRAC) : max_frac_digits;
    if (d_sum >= {1'b0, total_width}) k_sel = 3'd1;
    else if (room > {2'b00, nlim}) k_sel = nlim;
    else k_sel = room[2:0];

    scale   = pow10(k_r);
    fraw    = prod_r[PROD_W-1:FRAC_BITS+1];
    ge      = (fraw >= {1'b0, scale});
    allnine = 1'b1;
    for (int i = 0; i < INT_DIGITS; i++)
      if (ibcd_r[i] != 4'd9) allnine = 1'b0;
    c = 1'b1;
    for (int i = 0; i < INT_DIGITS; i++) begin
      inc[i] = ibcd_r[i];
      if (c) begin
        if (ibcd_r[i] == 4'd9) inc[i] = 4'd0;
        else begin
          inc[i] = ibcd_r[i] + 4'd1;
          c      = 1'b0;
        end
      end
    end

    idig_c = 4'd1;
    izero  = 1'b1;
    for (int i = 0; i < INT_DIGITS; i++)
      if (ibcd_r[i] != 4'd0) begin
        idig_c = 4'(i + 1);
        izero  = 1'b0;
      end
    fzero  = (fbcd_r == '0);
    tz     = 3'd0;
    tz_run = 1'b1;
    for (int i = 0; i < MAX_FRAC; i++)
      if (tz_run && fbcd_r[i] == 4'd0) tz = tz + 3'd1;
      else tz_run = 1'b0;

    pm1  = pos_r - 5'd1;
    ioff = {1'b0, idig_r} - pos_r;
    foff = pos_r - {1'b0, idig_r} - 5'd2;
    iidx = ioff[3:0];
    fidx = 2'({2'b00, k_r} - 5'd1 - foff);
  end

  always_comb begin
    neg_nxt  = neg_r;
    ibin_nxt = ibin_r;
    frac_nxt = frac_r;
    ibcd_nxt = ibcd_r;
    k_nxt    = k_r;
    prod_nxt = prod_r;
    fbin_nxt = fbin_r;
    fbcd_nxt = fbcd_r;
    idig_nxt = idig_r;
    keep_nxt = keep_r;
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    ch_nxt   = ch_r;
    lst_nxt  = lst_r;
    ov_nxt   = ov_r && !out_ready;

    if (cmd.load) begin
      neg_nxt  = value[VALUE_W-1];
      ibin_nxt = mag[VALUE_W-1:FRAC_BITS];
      frac_nxt = mag[FRAC_BITS-1:0];
      ibcd_nxt = '0;
    end
    if (cmd.ddi) begin
      ibcd_nxt[0] = {it[0][2:0], ibin_r[IPART_W-1]};
      for (int i = 1; i < INT_DIGITS; i++) ibcd_nxt[i] = {it[i][2:0], it[i-1][3]};
      ibin_nxt = {ibin_r[IPART_W-2:0], 1'b0};
    end
    if (cmd.mul) begin
      k_nxt    = k_sel;
      prod_nxt = PROD_W'({16'd0, frac_r} * {pow10(k_sel), 1'b0})
               + PROD_W'(33'd1 << FRAC_BITS);
    end
    if (cmd.rnd) begin
      fbcd_nxt = '0;
      if (ge && allnine) fbin_nxt = scale - 14'd1;
      else if (ge) begin
        fbin_nxt = FDIG_W'(fraw - {1'b0, scale});
        ibcd_nxt = inc;
      end else fbin_nxt = fraw[FDIG_W-1:0];
    end
    if (cmd.ddf) begin
      fbcd_nxt[0] = {ft[0][2:0], fbin_r[FDIG_W-1]};
      for (int i = 1; i < MAX_FRAC; i++) fbcd_nxt[i] = {ft[i][2:0], ft[i-1][3]};
      fbin_nxt = {fbin_r[FDIG_W-2:0], 1'b0};
    end
    if (cmd.fin) begin
      if (izero && fzero) neg_nxt = 1'b0;
      idig_nxt = idig_c;
      if (k_r == 3'd0) keep_nxt = 3'd0;
      else if (trim_zeros && tz >= k_r) keep_nxt = 3'd1;
      else if (trim_zeros) keep_nxt = k_r - tz;
      else keep_nxt = k_r;
      len_nxt = 5'd2 + {1'b0, idig_c} + {2'b00, (k_r == 3'd0) ? 3'd0 :
                (!trim_zeros) ? k_r : (tz >= k_r) ? 3'd1 : k_r - tz};
      pos_nxt = '0;
    end
    if (cmd.emit) begin
      if (pos_r == 5'd0) ch_nxt = neg_r ? CH_MINUS : CH_SPACE;
      else if (pm1 < {1'b0, idig_r}) ch_nxt = CH_ZERO + {4'd0, ibcd_r[iidx]};
      else if (pos_r == {1'b0, idig_r} + 5'd1) ch_nxt = CH_DOT;
      else ch_nxt = CH_ZERO + {4'd0, fbcd_r[fidx]};
      lst_nxt = sts.last;
      pos_nxt = pos_r + 5'd1;
      ov_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    neg_r  <= neg_nxt;
    ibin_r <= ibin_nxt;
    frac_r <= frac_nxt;
    ibcd_r <= ibcd_nxt;
    k_r    <= k_nxt;
    prod_r <= prod_nxt;
    fbin_r <= fbin_nxt;
    fbcd_r <= fbcd_nxt;
    idig_r <= idig_nxt;
    keep_r <= keep_nxt;
    len_r  <= len_nxt;
    pos_r  <= pos_nxt;
    ch_r   <= ch_nxt;
    lst_r  <= lst_nxt;
  end

  assign out_valid     = ov_r;
  assign out_text_char = ch_r;
  assign out_last      = lst_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> ov_r)
    else $error("emitted word not presented");
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> (len_r >= 5'd3 && len_r <= 5'd16 && keep_r <= k_r))
    else $error("text length out of range");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("output word overwritten");

endmodule
`default_nettype wire

### rtl/fixed_to_decimal_text_formatter.sv
// Top level of the decimal text formatter: configuration registers and the
// sequencer/datapath pair. Depends on fdtf_pkg, fdtf_ctrl and fdtf_dp.
//
// Usage: the input channel (in_valid/in_ready/in_value) takes one signed
// 48-bit value with 16 fraction bits. The output channel (out_valid/out_ready)
// then delivers its text one ASCII word per handshake on out_text_char, with
// out_last set on the final word (3 to 16 words per value).
// Sequence: a value passes through bit-serial integer BCD conversion, a
// multiply step, a rounding step, bit-serial fraction BCD conversion and a
// trim step, then one character per cycle while the output register is
// free. The next value is accepted once the final word sits in the output
// register.
// Reset (rst_n low, synchronous) empties the output register, returns the
// sequencer to idle and loads total_width = 8, max_frac_digits = 2,
// trim_zeros = 0. A stalled receiver holds the current word and pauses the
// character sequence; nothing is lost.
// Registers over the APB-style port: 0x0 total_width, 0x4 max_frac_digits,
// 0x8 trim_zeros; write only while idle.
`default_nettype none
module fixed_to_decimal_text_formatter import fdtf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_text_char,
  output logic                    out_last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [4:0] tw_r;
  logic [2:0] mfd_r;
  logic       trim_r;
  logic       wr;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r   <= 5'd8;
      mfd_r  <= 3'd2;
      trim_r <= 1'b0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_TOTAL_WIDTH: tw_r   <= pwdata[4:0];
        REG_MAX_FRAC:    mfd_r  <= pwdata[2:0];
        REG_TRIM:        trim_r <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TOTAL_WIDTH: prdata = {27'd0, tw_r};
      REG_MAX_FRAC:    prdata = {29'd0, mfd_r};
      REG_TRIM:        prdata = {31'd0, trim_r};
      default:         prdata = '0;
    endcase
  end

  fdtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fdtf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .value           (in_value),
    .total_width     (tw_r),
    .max_frac_digits (mfd_r),
    .trim_zeros      (trim_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_text_char   (out_text_char),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

### tb/fdtf_text_checker.sv
// Watches the value and text channels of the decimal text formatter, predicts the
// characters of each accepted value and compares them word by word.
// Depends on fdtf_pkg; the register settings come from the testbench top.
module fdtf_text_checker import fdtf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_text_char,
  input  logic               out_last,
  input  logic [4:0]         total_width,
  input  logic [2:0]         max_frac_digits,
  input  logic               trim_zeros,
  output int                 fail_count,
  output int                 pending_chars
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_word_t;

  text_word_t expected_text[$];

  function automatic int decimal_len(input longint unsigned v);
    int n;
    n = 1;
    while (v >= 10 && n < 20) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  task automatic format_value(input logic [VALUE_W-1:0] raw);
    logic [7:0] txt[$];
    logic [7:0] body[$];
    logic neg;
    logic [VALUE_W-1:0] mag;
    longint unsigned ip, fp, fd, scale, lim;
    int nl, d, k, idig, keep;
    text_word_t w;
    neg = raw[VALUE_W-1];
    mag = neg ? -raw : raw;
    ip = mag >> FRAC_BITS;
    fp = mag & ((64'd1 << FRAC_BITS) - 1);
    lim = 64'd9999999999;
    nl = (max_frac_digits > MAX_FRAC) ? MAX_FRAC : max_frac_digits;
    d = decimal_len(ip);
    if (d + 2 >= total_width) k = 1;
    else k = (total_width - d - 2 > nl) ? nl : total_width - d - 2;
    scale = 1;
    for (int i = 0; i < k; i++) scale = scale * 10;
    fd = (fp * scale * 2 + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
    if (fd >= scale) begin
      fd = fd - scale;
      ip = ip + 1;
    end
    if (ip > lim) begin
      ip = lim;
      fd = scale - 1;
    end
    if (ip == 0 && fd == 0) neg = 1'b0;
    idig = decimal_len(ip);
    if (idig > INT_DIGITS) idig = INT_DIGITS;
    txt.push_back(neg ? CH_MINUS : CH_SPACE);
    for (int i = 0; i < idig; i++) begin
      body.push_front(CH_ZERO + 8'(ip % 10));
      ip = ip / 10;
    end
    txt = {txt, body, CH_DOT};
    body.delete();
    for (int i = 0; i < k; i++) begin
      body.push_front(CH_ZERO + 8'(fd % 10));
      fd = fd / 10;
    end
    keep = k;
    if (trim_zeros) while (keep > 1 && body[keep-1] == CH_ZERO) keep--;
    for (int i = 0; i < keep; i++) txt.push_back(body[i]);
    foreach (txt[i]) begin
      w.ch = txt[i];
      w.last = (i == txt.size() - 1);
      expected_text.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    text_word_t e;
    if (rst_n) begin
      if (in_valid && in_ready) format_value(in_value);
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected word char=%h last=%b", out_text_char, out_last);
        end else begin
          e = expected_text.pop_front();
          if (e.ch !== out_text_char || e.last !== out_last) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp char=%h last=%b got char=%h last=%b",
                       e.ch, e.last, out_text_char, out_last);
          end
        end
      end
    end
    pending_chars <= expected_text.size();
  end

  initial fail_count = 0;
  initial pending_chars = 0;
endmodule

### tb/testbench.sv
// Stimulus and verdict for the decimal text formatter: directed and random values,
// register phases over the APB-style port, random idling and a long receiver hold.
// Depends on fdtf_pkg, the block and fdtf_text_checker.
module testbench import fdtf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic [VALUE_W-1:0] in_value = '0;
  logic in_ready, out_valid, out_last, pready;
  logic [7:0] out_text_char;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic [4:0] total_width = 5'd8;
  logic [2:0] max_frac_digits = 3'd2;
  logic trim_zeros = 0;
  logic calm = 0, hold_off = 0;
  int fail_count, pending_chars, idle_cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  fixed_to_decimal_text_formatter dut (.*);

  fdtf_text_checker checker_i (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= !hold_off && (calm || $urandom_range(99) >= 11);

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= data; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_TOTAL_WIDTH: total_width <= data[4:0];
      REG_MAX_FRAC:    max_frac_digits <= data[2:0];
      default:         trim_zeros <= data[0];
    endcase
    @(posedge clk);
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(5))
      0: v = {{16{v[47]}}, v[31:0]} >>> $urandom_range(31);
      1: v = {32'($urandom_range(99999)), 16'($urandom_range(65535))};
      2: v = -({$urandom_range(999), 16'd0} + {32'd0, v[15:0]});
      3: v = {v[47:16], 16'hFFFF - 16'($urandom_range(20))};
      default: ;
    endcase
    return v;
  endfunction

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] directed[$];
    directed = '{48'h0, 48'h1, 48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                 48'h0000_0000_8000, 48'hFFFF_FFFF_8000, 48'h0000_0009_FFFF,
                 48'h0000_0000_7FFF, 48'h0002_540B_E3FF, 48'h0002_540B_FFFF,
                 48'hFFFF_FFFF_FFF0, 48'h0000_0001_0000, 48'h5555_5555_5555,
                 48'hAAAA_AAAA_AAAA, 48'h0000_0063_FF00};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send_value(directed[i]);
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_TOTAL_WIDTH, 31); write_reg(REG_MAX_FRAC, 4); end
        1: begin write_reg(REG_TRIM, 1); write_reg(REG_MAX_FRAC, 7); end
        2: begin write_reg(REG_TOTAL_WIDTH, 0); write_reg(REG_MAX_FRAC, 0); end
        3: begin write_reg(REG_TOTAL_WIDTH, 14); write_reg(REG_MAX_FRAC, 0);
                 write_reg(REG_TRIM, 0); end
        4: begin write_reg(REG_TOTAL_WIDTH, 5); write_reg(REG_MAX_FRAC, 3); end
        5: begin write_reg(REG_TOTAL_WIDTH, 12); write_reg(REG_MAX_FRAC, 4);
                 write_reg(REG_TRIM, 1); end
        default: begin
          write_reg(REG_TOTAL_WIDTH, $urandom_range(31));
          write_reg(REG_MAX_FRAC, $urandom_range(7));
          write_reg(REG_TRIM, $urandom_range(1));
        end
      endcase
      if (phase < 3) foreach (directed[i]) send_value(directed[i]);
      calm <= (phase == 4);
      if (phase == 5) begin
        hold_off <= 1;
        fork
          begin repeat (300) @(posedge clk); hold_off <= 0; end
        join_none
      end
      for (int n = 0; n < 40; n++) send_value(random_value());
      calm <= 0;
      drain();
    end
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

### filelist.f
rtl/fdtf_pkg.sv
rtl/fdtf_ctrl.sv
rtl/fdtf_dp.sv
rtl/fixed_to_decimal_text_formatter.sv
tb/fdtf_text_checker.sv
tb/testbench.sv
